@@ sv/bspf_pkg.sv @@
// ----------------------------------------------------------------------------
// bspf_pkg: shared types and constants of the byte stream pattern finder
// Holds configuration register indexes, port widths and the per-cell flags.
// ----------------------------------------------------------------------------
package bspf_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_MATCH_MODE    = 2'd0;
  localparam logic [1:0] REG_SEARCH_LAST   = 2'd1;
  localparam logic [1:0] REG_PATTERN_BYTES = 2'd2;
  localparam logic [1:0] REG_PATTERN_COUNT = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;
  localparam int COUNT_W    = 4;
  localparam int OFFSET_W   = 17;
  localparam int OUT_DATA_W = 24;

  // Compare results one cell reports to the control logic.
  typedef struct packed {
    logic sub_eq;   // window byte equals its pattern byte
    logic set_eq;   // incoming byte equals this cell's set byte
  } cell_flags_t;

endpackage

@@ sv/bspf_cell.sv @@
// ----------------------------------------------------------------------------
// bspf_cell: one stage of the byte window
// Holds one window byte and passes it on when shifting is enabled. Compares the
// byte entering it to its substring byte, and the stream byte to its set byte.
// ----------------------------------------------------------------------------
module bspf_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 shift_en,
  input  logic                 clear,
  input  logic [7:0]           byte_in,
  input  logic [7:0]           in_byte,
  input  logic [7:0]           sub_pat,
  input  logic [7:0]           set_pat,
  output logic [7:0]           byte_out,
  output bspf_pkg::cell_flags_t flags
);

  logic [7:0] byte_r;
  logic [7:0] byte_nxt;

  always_comb begin
    byte_nxt = byte_r;
    if (clear) begin
      byte_nxt = 8'h00;
    end else if (shift_en) begin
      byte_nxt = byte_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= 8'h00;
    end else begin
      byte_r <= byte_nxt;
    end
  end

  // The substring compare looks at the window as it stands after this word.
  assign flags.sub_eq = (byte_in == sub_pat);
  assign flags.set_eq = (in_byte == set_pat);
  assign byte_out     = byte_r;

endmodule

@@ sv/byte_stream_pattern_finder.sv @@
// ----------------------------------------------------------------------------
// byte_stream_pattern_finder: first or last match of a pattern in a byte range
// Searches a byte stream for a substring of up to eight bytes or any byte of
// a set of up to eight bytes, and reports one result per range.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one byte per word; in_tlast marks the final byte
//   of a range. At that word a single result word is produced: found flag,
//   overflow flag and the start offset of the first or last match.
//   Configuration is written through cfg_wr_en / cfg_index / cfg_wdata while
//   no range is in progress.
// Throughput and output timing:
//   One byte is taken per cycle while the output register is not stalled. The
//   result is registered and appears on the output in the cycle after the last
//   byte of its range is accepted. The window is a row of MAX_PATTERN cells
//   that all compare in parallel, so pattern length does not slow the stream.
// Reset and stalls:
//   Reset clears the window, the range counters and the output valid flag and
//   loads the default configuration (substring mode, first match, length 1).
//   While a result waits on a stalled receiver, the next byte is still taken
//   only if the output register is freed in the same cycle.
// ----------------------------------------------------------------------------
module byte_stream_pattern_finder #(
  parameter int MAX_PATTERN = 8,
  parameter int MAX_RANGE   = 65536
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Input stream.
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] data_byte
  input  logic                              in_tlast,   // range_end
  // Result stream.
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [bspf_pkg::OUT_DATA_W-1:0]   out_tdata,  // [16:0] match_offset
  output logic [1:0]                        out_tuser,  // [0] found, [1] overflow
  // Configuration port.
  input  logic                              cfg_wr_en,
  input  logic [bspf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bspf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int CW = $clog2(MAX_RANGE + 1);
  localparam int OW = (CW > bspf_pkg::OFFSET_W) ? CW : bspf_pkg::OFFSET_W;

  // Configuration registers.
  logic                               match_mode_r;
  logic                               search_last_r;
  logic [bspf_pkg::CFG_DATA_W-1:0]    pattern_bytes_r;
  logic [bspf_pkg::COUNT_W-1:0]       pattern_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_mode_r    <= 1'b0;
      search_last_r   <= 1'b0;
      pattern_bytes_r <= '0;
      pattern_count_r <= bspf_pkg::COUNT_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        bspf_pkg::REG_MATCH_MODE:    match_mode_r    <= cfg_wdata[0];
        bspf_pkg::REG_SEARCH_LAST:   search_last_r   <= cfg_wdata[0];
        bspf_pkg::REG_PATTERN_BYTES: pattern_bytes_r <= cfg_wdata;
        bspf_pkg::REG_PATTERN_COUNT:
          pattern_count_r <= cfg_wdata[bspf_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Range state.
  logic [CW-1:0] bytes_seen_r, bytes_seen_nxt;
  logic          have_match_r, have_match_nxt;
  logic [CW-1:0] best_offset_r, best_offset_nxt;
  logic          saturated_r, saturated_nxt;

  // Output register.
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_found_r, out_found_nxt;
  logic                         out_ovf_r, out_ovf_nxt;
  logic [bspf_pkg::OFFSET_W-1:0] out_offset_r, out_offset_nxt;

  logic                         accept;
  logic                         sat_now;
  logic                         shift_en;
  logic                         clear;
  logic [bspf_pkg::COUNT_W-1:0] n_eff;
  logic [CW:0]                  pos_p1;
  logic [CW:0]                  n_ext;
  logic [CW-1:0]                sub_start;
  logic                         sub_all_eq;
  logic                         set_hit;
  logic                         match_ok;
  logic [CW-1:0]                match_start;
  logic                         res_found;
  logic [CW-1:0]                res_off;
  logic [OW-1:0]                res_off_ext;

  logic [7:0]            win   [MAX_PATTERN];
  bspf_pkg::cell_flags_t flags [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] sub_ok;
  logic [MAX_PATTERN-1:0] set_ok;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign sat_now   = (bytes_seen_r >= CW'(MAX_RANGE));
  assign shift_en  = accept && !sat_now;
  assign clear     = accept && in_tlast;

  assign n_eff = (pattern_count_r > bspf_pkg::COUNT_W'(MAX_PATTERN)) ?
                 bspf_pkg::COUNT_W'(MAX_PATTERN) : pattern_count_r;

  // Row of window cells; cell 0 holds the newest byte.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic [7:0] byte_in;
    logic [2:0] sub_idx;
    logic [7:0] sub_pat;

    if (k == 0) begin : g_head
      assign byte_in = in_tdata;
    end else begin : g_body
      assign byte_in = win[k-1];
    end

    // Window byte k lines up with pattern byte n-1-k.
    assign sub_idx = 3'(n_eff - bspf_pkg::COUNT_W'(k + 1));
    assign sub_pat = pattern_bytes_r[{sub_idx, 3'b000} +: 8];

    bspf_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (shift_en),
      .clear    (clear),
      .byte_in  (byte_in),
      .in_byte  (in_tdata),
      .sub_pat  (sub_pat),
      .set_pat  (pattern_bytes_r[k*8 +: 8]),
      .byte_out (win[k]),
      .flags    (flags[k])
    );

    assign sub_ok[k] = (bspf_pkg::COUNT_W'(k) >= n_eff) || flags[k].sub_eq;
    assign set_ok[k] = (bspf_pkg::COUNT_W'(k) <  n_eff) && flags[k].set_eq;
  end

  assign pos_p1    = {1'b0, bytes_seen_r} + {{CW{1'b0}}, 1'b1};
  assign n_ext     = (CW+1)'(n_eff);
  assign sub_start = CW'(pos_p1 - n_ext);
  assign sub_all_eq = (n_eff != '0) && (pos_p1 >= n_ext) && (&sub_ok);
  assign set_hit    = |set_ok;
  assign match_ok   = match_mode_r ? set_hit : sub_all_eq;
  assign match_start = match_mode_r ? bytes_seen_r : sub_start;

  always_comb begin
    bytes_seen_nxt  = bytes_seen_r;
    have_match_nxt  = have_match_r;
    best_offset_nxt = best_offset_r;
    saturated_nxt   = saturated_r;
    res_found       = 1'b0;
    res_off         = '0;

    if (accept) begin
      if (sat_now) begin
        saturated_nxt = 1'b1;
      end else begin
        bytes_seen_nxt = CW'(pos_p1);
        if (match_ok && (!have_match_r || search_last_r)) begin
          have_match_nxt  = 1'b1;
          best_offset_nxt = match_start;
        end
      end
    end

    res_found = have_match_nxt;
    res_off   = have_match_nxt ? best_offset_nxt : '0;
    // An empty substring matches at the range start or just past its end.
    if (!match_mode_r && (n_eff == '0)) begin
      res_found = 1'b1;
      res_off   = search_last_r ? bytes_seen_nxt : '0;
    end

    if (clear) begin
      bytes_seen_nxt  = '0;
      have_match_nxt  = 1'b0;
      best_offset_nxt = '0;
      saturated_nxt   = 1'b0;
    end
  end

  assign res_off_ext = OW'(res_off);

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_found_nxt  = out_found_r;
    out_ovf_nxt    = out_ovf_r;
    out_offset_nxt = out_offset_r;
    if (clear) begin
      out_valid_nxt  = 1'b1;
      out_found_nxt  = res_found;
      out_ovf_nxt    = saturated_r || sat_now;
      out_offset_nxt = res_off_ext[bspf_pkg::OFFSET_W-1:0];
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bytes_seen_r  <= '0;
      have_match_r  <= 1'b0;
      best_offset_r <= '0;
      saturated_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      bytes_seen_r  <= bytes_seen_nxt;
      have_match_r  <= have_match_nxt;
      best_offset_r <= best_offset_nxt;
      saturated_r   <= saturated_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r  <= out_found_nxt;
    out_ovf_r    <= out_ovf_nxt;
    out_offset_r <= out_offset_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = bspf_pkg::OUT_DATA_W'(out_offset_r);
  assign out_tuser  = {out_ovf_r, out_found_r};

  // A waiting result blocks new bytes unless it is taken this cycle.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !in_tready)
    else $error("input accepted while result register is stalled");

  // The last byte of a range always leaves clean range state behind.
  a_range_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tlast) |=>
      (bytes_seen_r == '0) && !have_match_r && !saturated_r && out_valid_r)
    else $error("range state not cleared after last byte");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_seen_r <= CW'(MAX_RANGE))
    else $error("byte counter ran past its limit");

  a_saturated_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
    saturated_r |-> (bytes_seen_r == CW'(MAX_RANGE)))
    else $error("overflow flag set below the range limit");

  a_offset_zero_when_missing: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_offset_r == '0))
    else $error("nonzero offset reported without a match");

endmodule

@@ tb/tb_byte_stream_pattern_finder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_stream_pattern_finder: self-checking bench for the pattern finder
// Streams byte ranges into the block under several register settings, idle and
// stall patterns. Each result word is checked against a cycle-free model of
// the substring and character-set search kept inside this bench.
// ----------------------------------------------------------------------------
module tb_byte_stream_pattern_finder;

  localparam int RANGE_LIMIT = 65536;
  localparam int CYCLE_LIMIT = 1000000;

  localparam logic MODE_SUBSTRING = 1'b0;
  localparam logic MODE_SET       = 1'b1;
  localparam logic PICK_FIRST     = 1'b0;
  localparam logic PICK_LAST      = 1'b1;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } stream_word_t;

  typedef struct packed {
    logic                          found;
    logic [bspf_pkg::OFFSET_W-1:0] offset;
    logic                          overflow;
  } search_result_t;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata = 8'h00;
  logic                            in_tlast = 1'b0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [bspf_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                      out_tuser;
  logic                            cfg_wr_en = 1'b0;
  logic [bspf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bspf_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  byte_stream_pattern_finder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Register copies, kept in step with every write.
  logic        cfg_mode  = MODE_SUBSTRING;
  logic        cfg_last  = PICK_FIRST;
  logic [63:0] cfg_pat   = '0;
  logic [3:0]  cfg_count = 4'd1;

  // Search state of the current range.
  logic [7:0]                    win [8] = '{default: 8'h00};
  int                            seen_cnt = 0;
  logic                          hit_valid = 1'b0;
  logic [bspf_pkg::OFFSET_W-1:0] hit_offset = '0;
  logic                          sat_flag = 1'b0;

  stream_word_t   pending_bytes [$];
  search_result_t expected_results [$];
  stream_word_t   next_word;
  search_result_t want;
  int             idle_pct = 0;
  int             stall_pct = 0;
  int             errors = 0;
  int             cycle_count = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void note_hit(int start);
    if (!hit_valid || cfg_last == PICK_LAST) begin
      hit_valid  = 1'b1;
      hit_offset = start[bspf_pkg::OFFSET_W-1:0];
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic fin);
    int             n;
    int             pos;
    logic           eq;
    logic           hit;
    search_result_t r;
    n = (cfg_count > 4'd8) ? 8 : int'(cfg_count);
    if (seen_cnt >= RANGE_LIMIT) begin
      sat_flag = 1'b1;
    end else begin
      pos = seen_cnt;
      for (int i = 7; i > 0; i--) win[i] = win[i-1];
      win[0] = b;
      if (cfg_mode == MODE_SET) begin
        hit = 1'b0;
        for (int i = 0; i < n; i++) if (cfg_pat[8*i +: 8] == b) hit = 1'b1;
        if (hit) note_hit(pos);
      end else if (n > 0 && pos + 1 >= n) begin
        eq = 1'b1;
        for (int i = 0; i < n; i++) if (win[n-1-i] != cfg_pat[8*i +: 8]) eq = 1'b0;
        if (eq) note_hit(pos + 1 - n);
      end
      seen_cnt = pos + 1;
    end
    if (fin) begin
      r.found    = hit_valid;
      r.offset   = hit_valid ? hit_offset : '0;
      r.overflow = sat_flag;
      // An empty substring always matches, at the start or past the end.
      if (cfg_mode == MODE_SUBSTRING && n == 0) begin
        r.found  = 1'b1;
        r.offset = (cfg_last == PICK_LAST) ? seen_cnt[bspf_pkg::OFFSET_W-1:0] : '0;
      end
      expected_results.push_back(r);
      for (int i = 0; i < 8; i++) win[i] = 8'h00;
      seen_cnt   = 0;
      hit_valid  = 1'b0;
      hit_offset = '0;
      sat_flag   = 1'b0;
    end
  endfunction

  // Input side: predicts on acceptance and presents the next pending word.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_word = pending_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_word.data;
          in_tlast  <= next_word.fin;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Result side.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("result word with no expected result: tdata %h tuser %b",
               out_tdata, out_tuser);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_tuser[0] !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, out_tuser[0]);
          errors++;
        end
        if (out_tdata !== {{(bspf_pkg::OUT_DATA_W-bspf_pkg::OFFSET_W){1'b0}},
                           want.offset}) begin
          $error("match_offset: expected %0d, actual %0d", want.offset, out_tdata);
          errors++;
        end
        if (out_tuser[1] !== want.overflow) begin
          $error("overflow: expected %0d, actual %0d", want.overflow, out_tuser[1]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void push_byte(logic [7:0] b, logic fin);
    stream_word_t w;
    w.data = b;
    w.fin  = fin;
    pending_bytes.push_back(w);
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
  endfunction

  // Ranges are mostly built from pattern bytes and whole patterns so that
  // matches, near misses and overlaps are common; some are plain noise.
  function automatic int add_random_range();
    int         n;
    int         len;
    int         k;
    int         j;
    logic       noise;
    logic [7:0] range_bytes [$];
    n     = (cfg_count > 4'd8) ? 8 : int'(cfg_count);
    len   = ($urandom_range(9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 12);
    noise = ($urandom_range(9) == 0);
    while (range_bytes.size() < len) begin
      k = $urandom_range(99);
      if (!noise && cfg_mode == MODE_SUBSTRING && n > 0 && k < 30) begin
        for (int i = 0; i < n; i++) range_bytes.push_back(cfg_pat[8*i +: 8]);
      end else if (!noise && k < 70) begin
        j = $urandom_range(7);
        range_bytes.push_back(cfg_pat[8*j +: 8]);
      end else begin
        range_bytes.push_back(8'($urandom_range(255)));
      end
    end
    for (int i = 0; i < range_bytes.size(); i++)
      push_byte(range_bytes[i], i == range_bytes.size() - 1);
    return range_bytes.size();
  endfunction

  task automatic write_reg(logic [bspf_pkg::CFG_IDX_W-1:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    unique case (idx)
      bspf_pkg::REG_MATCH_MODE:    cfg_mode  = val[0];
      bspf_pkg::REG_SEARCH_LAST:   cfg_last  = val[0];
      bspf_pkg::REG_PATTERN_BYTES: cfg_pat   = val;
      bspf_pkg::REG_PATTERN_COUNT: cfg_count = val[3:0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic mode, logic pick, logic [63:0] pat, logic [3:0] cnt);
    write_reg(bspf_pkg::REG_MATCH_MODE, 64'(mode));
    write_reg(bspf_pkg::REG_SEARCH_LAST, 64'(pick));
    write_reg(bspf_pkg::REG_PATTERN_BYTES, pat);
    write_reg(bspf_pkg::REG_PATTERN_COUNT, 64'(cnt));
  endtask

  task automatic random_config();
    logic [63:0] pat;
    logic [3:0]  cnt;
    int          r;
    pat = {$urandom, $urandom};
    // A two-letter alphabet gives overlapping and repeated patterns.
    if ($urandom_range(2) == 0)
      for (int i = 0; i < 8; i++) pat[8*i +: 8] = 8'(8'h41 + $urandom_range(1));
    r = $urandom_range(99);
    if (r < 10)      cnt = 4'd0;
    else if (r < 15) cnt = 4'($urandom_range(9, 15));
    else if (r < 25) cnt = 4'd8;
    else             cnt = 4'($urandom_range(1, 4));
    set_config(1'($urandom_range(1)), 1'($urandom_range(1)), pat, cnt);
  endtask

  // The block produces nothing for non-final words, so this waits until every
  // queued word is sent and every expected result is taken before registers are touched.
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int queued;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: single zero byte, first match.
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    wait_idle();
    set_config(MODE_SUBSTRING, PICK_FIRST, 64'h4241, 4'd2);
    push_text("xABAB");
    push_text("A");            // pattern longer than the range
    wait_idle();
    set_config(MODE_SUBSTRING, PICK_LAST, 64'h4241, 4'd2);
    push_text("ABAB");
    wait_idle();
    set_config(MODE_SUBSTRING, PICK_LAST, 64'h4241, 4'd0);
    push_text("xy");
    wait_idle();
    set_config(MODE_SUBSTRING, PICK_FIRST, 64'h4241, 4'd0);
    push_text("q");
    wait_idle();
    set_config(MODE_SET, PICK_FIRST, '1, 4'd0);
    push_byte(8'hFF, 1'b1);    // empty set never matches
    wait_idle();
    set_config(MODE_SET, PICK_LAST, 64'hFF00_1122_3344_5566, 4'd8);
    push_byte(8'h00, 1'b0);
    push_byte(8'h7E, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b1);
    wait_idle();
    set_config(MODE_SUBSTRING, PICK_FIRST, 64'h4847_4645_4443_4241, 4'd15);
    push_text("ABCDEFGH");

    for (int phase = 0; phase < 4; phase++) begin
      for (int s = 0; s < 3; s++) begin
        wait_idle();
        unique case (phase)
          0: begin idle_pct = 0;  stall_pct = 0;  end
          1: begin idle_pct = 59; stall_pct = 0;  end
          2: begin idle_pct = 0;  stall_pct = 59; end
          default: begin idle_pct = 18; stall_pct = 18; end
        endcase
        random_config();
        queued = 0;
        while (queued < 150) queued += add_random_range();
      end
    end

    wait_idle();
    if (errors == 0 && expected_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/bspf_pkg.sv
sv/bspf_cell.sv
sv/byte_stream_pattern_finder.sv
tb/tb_byte_stream_pattern_finder.sv
